>>> hw/rtl/twcr_pkg.sv
// ----------------------------------------------------------------------------
// Textured wall column renderer package
// Shared widths, constants and payload types.
// ----------------------------------------------------------------------------
package twcr_pkg;

    localparam int TILE_PIXELS = 64;
    localparam int TEX_SIDE    = 64;
    localparam int TEX_COUNT   = 4;
    localparam int TILE_BITS   = $clog2(TILE_PIXELS);
    localparam int SIDE_BITS   = $clog2(TEX_SIDE);
    localparam int PICK_BITS   = $clog2(TEX_COUNT);
    localparam int IDX_BITS    = 2 * SIDE_BITS;
    localparam int TEX_ADDR_W  = PICK_BITS + IDX_BITS;
    localparam int TEX_DEPTH   = TEX_COUNT * TEX_SIDE * TEX_SIDE;

    // Divider widths: dividend below 64 * 2^24, divisor below 2^25.
    localparam int DIV_NUM_W   = 24 + TILE_BITS;
    localparam int DIV_DEN_W   = 25;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

    localparam logic [15:0] STRIP_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_FETCH = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // Wall texture numbers.
    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_EAST  = 2'd3;

    localparam logic REG_SCREEN_HEIGHT = 1'b0;
    localparam logic REG_PROJECTION    = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  texture_pick;
        logic [11:0] texel_index;
        logic [31:0] texel_color;
        logic [23:0] ray_distance;
        logic [15:0] cos_offset;
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic        hit_vertical;
        logic        facing_up;
        logic        facing_left;
        logic [11:0] row;
    } t_in_item;

    typedef struct packed {
        logic [31:0] color;
        logic        in_wall;
        logic [12:0] wall_top;
        logic [12:0] wall_bottom;
        logic [15:0] strip_height;
    } t_out_item;

endpackage

>>> hw/rtl/twcr_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one renderer operation.
// ----------------------------------------------------------------------------
interface twcr_in_if;
    logic                 valid;
    logic                 ready;
    twcr_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/twcr_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one renderer result.
// ----------------------------------------------------------------------------
interface twcr_out_if;
    logic                 valid;
    logic                 ready;
    twcr_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/textured_wall_column_renderer.sv
// ----------------------------------------------------------------------------
// Textured wall column renderer
// Texel store, column set-up and per-row texture fetch for a raycaster.
//
//   Channel   Direction  Contents
//   i_in      sink       mode, texel write, column load or row fetch fields
//   o_out     source     colour, in_wall, wall top/bottom, strip height
//   config    write      screen_height (0), projection_distance (1)
//
// A texel write or no-op goes from idle to the output state, a row outside the
// wall first through the fetch state. A column load runs the multiply state and
// the one-bit-per-cycle divider (30 quotient bits); a row inside the wall runs
// the divider and then the registered texture read. One operation is in flight
// at a time; the next input transfer is taken from the cycle after the result is
// registered. An operation holds in its last state only while the previous
// result is not taken. Reset is synchronous and active low; it clears the column
// state and restores the register defaults. Texture memory is not cleared.
// ----------------------------------------------------------------------------
module textured_wall_column_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data,
    twcr_in_if.sink     i_in,
    twcr_out_if.source  o_out
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_FETCH, S_READ, S_RDATA, S_OUT
    } t_state;

    t_state             r_state;
    twcr_pkg::t_in_item r_item;
    logic [12:0]        r_height;
    logic [23:0]        r_proj;
    logic [15:0]        r_strip;
    logic [12:0]        r_top;
    logic [12:0]        r_bottom;
    logic [twcr_pkg::SIDE_BITS-1:0] r_texcol;
    logic [twcr_pkg::PICK_BITS-1:0] r_tex;
    logic [39:0]        r_prod;
    logic               r_out_valid;
    twcr_pkg::t_out_item r_out;
    logic [twcr_pkg::SIDE_BITS-1:0] r_yoff;
    logic               r_in_wall;

    logic                                 div_start;
    logic [twcr_pkg::DIV_NUM_W-1:0]       div_num;
    logic [twcr_pkg::DIV_DEN_W-1:0]       div_den;
    logic                                 div_done;
    logic [twcr_pkg::DIV_NUM_W-1:0]       div_quot;
    logic                                 ram_we;
    logic [twcr_pkg::TEX_ADDR_W-1:0]      ram_addr;
    logic [31:0]                          ram_rdata;

    logic [11:0] half_h;
    logic [14:0] n_strip_half;
    logic [15:0] n_strip;
    logic [12:0] n_top;
    logic [15:0] n_bot_sum;
    logic [12:0] n_bottom;
    logic [24:0] n_perp;
    logic [15:0] n_coord;
    logic        n_row_in;
    logic [16:0] n_dsum;
    logic [16:0] n_dist;
    logic        accept;
    logic        out_load;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign half_h     = r_height[12:1];
    assign n_perp     = r_prod[39:15];

    // The result register takes a new result once the previous one has gone.
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // Strip saturation and clamping from the divider quotient; row test and texture distance.
    always_comb begin
        if (n_perp == '0 || div_quot > twcr_pkg::DIV_NUM_W'(twcr_pkg::STRIP_MAX)) begin
            n_strip = twcr_pkg::STRIP_MAX;
        end else begin
            n_strip = div_quot[15:0];
        end
        n_strip_half = n_strip[15:1];
        n_top = ({3'b0, n_strip_half} >= {6'b0, half_h}) ? 13'd0
              : 13'({6'b0, half_h} - {3'b0, n_strip_half});
        n_bot_sum = {4'b0, half_h} + {1'b0, n_strip_half};
        n_bottom  = (n_bot_sum > {3'b0, r_height}) ? r_height : n_bot_sum[12:0];
        n_coord   = r_item.hit_vertical ? r_item.hit_y : r_item.hit_x;
        n_row_in  = ({1'b0, r_item.row} >= r_top) && ({1'b0, r_item.row} < r_bottom)
                 && (r_strip != '0);
        n_dsum    = {5'b0, r_item.row} + {2'b0, r_strip[15:1]};
        n_dist    = (n_dsum >= {5'b0, half_h}) ? n_dsum - {5'b0, half_h} : 17'd0;
    end

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (r_state == S_MUL) begin
            div_start = 1'b1;
            div_num   = {r_proj, {twcr_pkg::TILE_BITS{1'b0}}};
            div_den   = (n_perp == '0) ? 25'd1 : n_perp;
        end else if (r_state == S_FETCH && n_row_in) begin
            div_start = 1'b1;
            div_num   = twcr_pkg::DIV_NUM_W'({n_dist, {twcr_pkg::SIDE_BITS{1'b0}}});
            div_den   = twcr_pkg::DIV_DEN_W'(r_strip);
        end
    end

    twcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Texture memory address: write port in idle, row read after the divide.
    always_comb begin
        ram_we   = accept && (i_in.data.mode == twcr_pkg::MODE_WRITE);
        if (r_state == S_IDLE) begin
            ram_addr = {i_in.data.texture_pick, i_in.data.texel_index};
        end else begin
            ram_addr = {r_tex, r_yoff, r_texcol};
        end
    end

    twcr_ram #(
        .WIDTH (32),
        .DEPTH (twcr_pkg::TEX_DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.data.texel_color),
        .o_rdata (ram_rdata)
    );

    // Sequencer, column state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_height    <= 13'd480;
            r_proj      <= 24'd141891;
            r_strip     <= '0;
            r_top       <= '0;
            r_bottom    <= '0;
            r_texcol    <= '0;
            r_tex       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == twcr_pkg::REG_SCREEN_HEIGHT) begin
                    r_height <= i_cfg_data[12:0];
                end else begin
                    r_proj <= i_cfg_data;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item <= i_in.data;
                        unique case (i_in.data.mode)
                            twcr_pkg::MODE_LOAD:  r_state <= S_MUL;
                            twcr_pkg::MODE_FETCH: r_state <= S_FETCH;
                            default:              r_state <= S_OUT;
                        endcase
                        r_prod <= 40'(i_in.data.ray_distance) * 40'(i_in.data.cos_offset);
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_strip  <= n_strip;
                        r_top    <= n_top;
                        r_bottom <= n_bottom;
                        r_texcol <= twcr_pkg::SIDE_BITS'(
                            (32'(n_coord[twcr_pkg::TILE_BITS-1:0]) * twcr_pkg::TEX_SIDE)
                            / twcr_pkg::TILE_PIXELS);
                        r_tex    <= r_item.hit_vertical
                                  ? (r_item.facing_left ? twcr_pkg::TEX_EAST
                                                        : twcr_pkg::TEX_WEST)
                                  : (r_item.facing_up ? twcr_pkg::TEX_SOUTH
                                                      : twcr_pkg::TEX_NORTH);
                        r_state  <= S_OUT;
                    end
                end
                S_FETCH: begin
                    r_in_wall <= n_row_in;
                    r_yoff    <= '0;
                    r_state   <= n_row_in ? S_READ : S_OUT;
                end
                S_READ: begin
                    if (div_done) begin
                        r_yoff  <= (div_quot > twcr_pkg::DIV_NUM_W'(twcr_pkg::TEX_SIDE - 1))
                                 ? twcr_pkg::SIDE_BITS'(twcr_pkg::TEX_SIDE - 1)
                                 : div_quot[twcr_pkg::SIDE_BITS-1:0];
                        r_state <= S_RDATA;
                    end
                end
                S_RDATA: begin
                    // The texel address is complete; the memory reads it at this edge.
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Memory data for a row fetch arrives this cycle.
                    if (out_load) begin
                        r_out.color        <= (r_item.mode == twcr_pkg::MODE_FETCH && r_in_wall)
                                            ? ram_rdata : 32'd0;
                        r_out.in_wall      <= (r_item.mode == twcr_pkg::MODE_FETCH) && r_in_wall;
                        r_out.wall_top     <= r_top;
                        r_out.wall_bottom  <= r_bottom;
                        r_out.strip_height <= r_strip;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

>>> hw/rtl/twcr_ram.sv
// ----------------------------------------------------------------------------
// Generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module twcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/twcr_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twcr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [twcr_pkg::DIV_NUM_W-1:0]      i_num,
    input  logic [twcr_pkg::DIV_DEN_W-1:0]      i_den,
    output logic                                o_done,
    output logic [twcr_pkg::DIV_NUM_W-1:0]      o_quot
);
    localparam int NW = twcr_pkg::DIV_NUM_W;
    localparam int DW = twcr_pkg::DIV_DEN_W;

    logic [NW-1:0]                   r_quot;
    logic [DW:0]                     r_rem;
    logic [DW-1:0]                   r_den;
    logic [twcr_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [DW:0]                     n_trial;
    logic [DW:0]                     n_shift;

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
        n_shift = {r_rem[DW-1:0], r_quot[NW-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= twcr_pkg::DIV_CNT_W'(NW);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_trial[DW]) begin
                    r_rem <= n_trial;
                end else begin
                    r_rem <= n_shift;
                end
                r_quot <= {r_quot[NW-2:0], ~n_trial[DW]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == twcr_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
